### rtl/tcf_pkg.sv
// Shared types, register indexes, reset values and the arctangent table of the tilt filter.
package tcf_pkg;

  // Register indexes on the configuration channel.
  localparam logic [7:0] CFG_BLEND_WEIGHT = 8'd0;
  localparam logic [7:0] CFG_RATE_GAIN    = 8'd1;

  // Register reset values.
  localparam logic [15:0] BLEND_WEIGHT_RESET = 16'd64225;
  localparam logic [23:0] RATE_GAIN_RESET    = 24'd65536;

  // Input mode codes.
  localparam logic MODE_START  = 1'b0;
  localparam logic MODE_UPDATE = 1'b1;

  // Sequencer of one accelerometer angle unit.
  typedef enum logic [2:0] {
    A_IDLE,
    A_SUM,
    A_ROOT,
    A_SETUP,
    A_ROTATE,
    A_FINISH
  } ang_state_t;

  // Sequencer of the top level.
  typedef enum logic [1:0] {
    T_IDLE,
    T_ANGLE,
    T_BLEND,
    T_STORE
  } top_state_t;

  // Arctangent of 2^-i as a 32-bit binary angle of a full turn.
  function automatic logic [31:0] arctan_turn(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

### rtl/tcf_angle.sv
// Accelerometer tilt angle unit: squares, digit-serial square root and iterated CORDIC.
module tcf_angle #(
  parameter int SAMPLE_BITS  = 16,
  parameter int ANGLE_BITS   = 20,
  parameter int CORDIC_STEPS = 20
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [SAMPLE_BITS-1:0] a,
  input  logic signed [SAMPLE_BITS-1:0] b,
  input  logic signed [SAMPLE_BITS-1:0] c,
  input  logic                          z_neg,
  output logic                          done,
  output logic [ANGLE_BITS-1:0]         angle
);

  localparam int PRESCALE = 30 - SAMPLE_BITS;
  localparam int SQ_W     = 2 * SAMPLE_BITS + 2;
  localparam int RAD_W    = SQ_W + 2 * PRESCALE;
  localparam int ROOT_W   = RAD_W / 2;
  localparam int REM_W    = ROOT_W + 3;
  localparam int XW       = 34;
  localparam int SH       = 32 - ANGLE_BITS;
  localparam int CNT_W    = 6;
  localparam logic [32:0] HALF = (33'd1 << SH) >> 1;

  tcf_pkg::ang_state_t state, state_next;

  logic signed [2*SAMPLE_BITS-1:0] bsq, csq;
  logic signed [SAMPLE_BITS-1:0]   a_q;
  logic                            zn_q;
  logic [RAD_W-1:0]                rad;
  logic [REM_W-1:0]                rem;
  logic [ROOT_W-1:0]               root;
  logic signed [XW-1:0]            x, y;
  logic [31:0]                     z;
  logic [CNT_W-1:0]                cnt;

  logic [SQ_W-1:0]      sum_sq;
  logic [REM_W-1:0]     rem_sh, trial;
  logic signed [XW-1:0] xs, ys;
  logic [31:0]          zm;
  logic [32:0]          rnd;
  logic                 root_last, rot_last, zero_vec;

  assign sum_sq    = SQ_W'(unsigned'(bsq)) + SQ_W'(unsigned'(csq));
  assign rem_sh    = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
  assign trial     = {1'b0, root, 2'b01};
  assign xs        = x >>> cnt[4:0];
  assign ys        = y >>> cnt[4:0];
  assign root_last = (cnt == CNT_W'(ROOT_W - 1));
  assign rot_last  = (cnt == CNT_W'(CORDIC_STEPS - 1));
  assign zero_vec  = (root == '0) && (a_q == '0);

  // Mirror for negative Z, then round to the output angle width.
  assign zm    = zn_q ? (32'h8000_0000 - z) : z;
  assign rnd   = {1'b0, zm} + HALF;
  assign angle = rnd[31:SH];
  assign done  = (state == tcf_pkg::A_FINISH);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcf_pkg::A_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      tcf_pkg::A_IDLE:   if (start) state_next = tcf_pkg::A_SUM;
      tcf_pkg::A_SUM:    state_next = tcf_pkg::A_ROOT;
      tcf_pkg::A_ROOT:   if (root_last) state_next = tcf_pkg::A_SETUP;
      tcf_pkg::A_SETUP:  state_next = zero_vec ? tcf_pkg::A_FINISH : tcf_pkg::A_ROTATE;
      tcf_pkg::A_ROTATE: if (rot_last) state_next = tcf_pkg::A_FINISH;
      tcf_pkg::A_FINISH: state_next = tcf_pkg::A_IDLE;
      default:           state_next = tcf_pkg::A_IDLE;
    endcase
  end

  // Datapath: one square root bit or one CORDIC rotation per cycle.
  always_ff @(posedge clk) begin
    case (state)
      tcf_pkg::A_IDLE: begin
        bsq  <= b * b;
        csq  <= c * c;
        a_q  <= a;
        zn_q <= z_neg;
      end
      tcf_pkg::A_SUM: begin
        rad  <= {sum_sq, {(2*PRESCALE){1'b0}}};
        rem  <= '0;
        root <= '0;
        cnt  <= '0;
      end
      tcf_pkg::A_ROOT: begin
        rad <= rad << 2;
        cnt <= cnt + 1'b1;
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[ROOT_W-2:0], 1'b0};
        end
      end
      tcf_pkg::A_SETUP: begin
        x   <= XW'(root);
        y   <= XW'(a_q) <<< PRESCALE;
        z   <= '0;
        cnt <= '0;
      end
      tcf_pkg::A_ROTATE: begin
        cnt <= cnt + 1'b1;
        if (!y[XW-1]) begin
          x <= x + ys;
          y <= y - xs;
          z <= z + tcf_pkg::arctan_turn(cnt[4:0]);
        end else begin
          x <= x - ys;
          y <= y + xs;
          z <= z - tcf_pkg::arctan_turn(cnt[4:0]);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/tcf_blend.sv
// Three-stage blend of one filtered angle toward the accelerometer angle.
module tcf_blend #(
  parameter int SAMPLE_BITS = 16,
  parameter int ANGLE_BITS  = 20
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ANGLE_BITS-1:0]       comp,
  input  logic [ANGLE_BITS-1:0]       acc,
  input  logic signed [SAMPLE_BITS:0] omega,
  input  logic [15:0]                 weight,
  input  logic [23:0]                 gain,
  output logic                        valid,
  output logic [ANGLE_BITS-1:0]       angle
);

  localparam int DW  = ANGLE_BITS + 2;
  localparam int PW1 = SAMPLE_BITS + 1 + 25;
  localparam int TW  = ((DW > PW1 - 16) ? DW : PW1 - 16) + 1;
  localparam int PW2 = TW + 17;
  localparam logic signed [DW-1:0] HALF = DW'(1) <<< (ANGLE_BITS - 1);
  localparam logic signed [DW-1:0] FULL = DW'(1) <<< ANGLE_BITS;
  localparam logic signed [PW2-1:0] ROUND = PW2'(32'h8000);

  logic signed [DW-1:0]  raw, diff_w, diff;
  logic signed [PW1-1:0] prod1;
  logic signed [PW2-1:0] prod2;
  logic signed [TW-1:0]  t;
  logic signed [PW2-1:0] p;
  logic [ANGLE_BITS-1:0] acc_q1, acc_q2;
  logic                  v1, v2;

  // Shortest signed difference; an exact half turn keeps the sign of the raw difference.
  assign raw = $signed({2'b00, comp}) - $signed({2'b00, acc});
  always_comb begin
    if (raw > HALF) begin
      diff_w = raw - FULL;
    end else if (raw < -HALF) begin
      diff_w = raw + FULL;
    end else begin
      diff_w = raw;
    end
  end

  assign t = TW'(diff) + TW'(prod1 >>> 16);
  assign p = (prod2 + ROUND) >>> 16;

  // Stage registers.
  always_ff @(posedge clk) begin
    prod1  <= omega * $signed({1'b0, gain});
    diff   <= diff_w;
    acc_q1 <= acc;
    prod2  <= PW2'(t) * PW2'($signed({1'b0, weight}));
    acc_q2 <= acc_q1;
    angle  <= acc_q2 + p[ANGLE_BITS-1:0];
  end

  // Valid travels alongside the stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      valid <= 1'b0;
    end else begin
      v1    <= start;
      v2    <= v1;
      valid <= v2;
    end
  end

endmodule

### rtl/tilt_complementary_filter.sv
// Top level of the six-axis complementary tilt filter.
//
//  Channel   Signals                              Carries
//  s_axis    s_tvalid s_tready s_tdata s_tuser    one sample set and its mode
//  m_axis    m_tvalid m_tready m_tdata            filtered and accelerometer angles
//  cfg       cfg_valid cfg_ready cfg_index cfg_data  register writes
//
// Each item runs the square root and the CORDIC loop, with both angles computed side by
// side; an update also passes through the blend stages. The result becomes valid in the
// same cycle as the input is opened for the next item.
// Reset clears the filtered angles to zero and loads the register defaults.
// A finished result waits in the output register; the next item is taken
// meanwhile, and its result is held back until the output register is free.
module tilt_complementary_filter #(
  parameter int ANGLE_BITS   = 20,
  parameter int SAMPLE_BITS  = 16,
  parameter int CORDIC_STEPS = 20
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // accel_x, accel_y, accel_z, rate_x, rate_y, then zero fill
  input  logic [((5*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
  // mode
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // tilt_x, tilt_y, accel_tilt_x, accel_tilt_y, then zero fill
  output logic [((4*ANGLE_BITS+7)/8)*8-1:0] m_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [7:0]            cfg_index,
  input  logic [23:0]           cfg_data
);

  localparam int SB    = SAMPLE_BITS;
  localparam int OUT_W = ((4*ANGLE_BITS+7)/8)*8;

  tcf_pkg::top_state_t state, state_next;

  logic [15:0] blend_weight;
  logic [23:0] rate_gain;
  logic [ANGLE_BITS-1:0] filt_x, filt_y, acc_x, acc_y;
  logic        mode_q;
  logic signed [SB-1:0] rate_x_q, rate_y_q;

  logic signed [SB-1:0] ax, ay, az, rx, ry;
  logic        in_fire, ux_done, uy_done, bx_valid, by_valid, blend_start, out_free;
  logic [ANGLE_BITS-1:0] ux_angle, uy_angle, bx_angle, by_angle;

  assign ax = $signed(s_tdata[0*SB +: SB]);
  assign ay = $signed(s_tdata[1*SB +: SB]);
  assign az = $signed(s_tdata[2*SB +: SB]);
  assign rx = $signed(s_tdata[3*SB +: SB]);
  assign ry = $signed(s_tdata[4*SB +: SB]);

  assign s_tready    = (state == tcf_pkg::T_IDLE);
  assign cfg_ready   = 1'b1;
  assign in_fire     = s_tvalid && s_tready;
  assign out_free    = !m_tvalid || m_tready;
  assign blend_start = (state == tcf_pkg::T_ANGLE) && ux_done && (mode_q == tcf_pkg::MODE_UPDATE);

  // Angle units for the X and Y tilt.
  tcf_angle #(.SAMPLE_BITS(SAMPLE_BITS), .ANGLE_BITS(ANGLE_BITS),
              .CORDIC_STEPS(CORDIC_STEPS)) u_ang_x (
    .clk(clk), .rst(rst), .start(in_fire), .a(ax), .b(ay), .c(az),
    .z_neg(az[SB-1]), .done(ux_done), .angle(ux_angle)
  );

  tcf_angle #(.SAMPLE_BITS(SAMPLE_BITS), .ANGLE_BITS(ANGLE_BITS),
              .CORDIC_STEPS(CORDIC_STEPS)) u_ang_y (
    .clk(clk), .rst(rst), .start(in_fire), .a(ay), .b(ax), .c(az),
    .z_neg(az[SB-1]), .done(uy_done), .angle(uy_angle)
  );

  // Blend units; negated gyro Y drives X, gyro X drives Y.
  tcf_blend #(.SAMPLE_BITS(SAMPLE_BITS), .ANGLE_BITS(ANGLE_BITS)) u_blend_x (
    .clk(clk), .rst(rst), .start(blend_start), .comp(filt_x), .acc(ux_angle),
    .omega(-((SB+1)'(rate_y_q))), .weight(blend_weight), .gain(rate_gain),
    .valid(bx_valid), .angle(bx_angle)
  );

  tcf_blend #(.SAMPLE_BITS(SAMPLE_BITS), .ANGLE_BITS(ANGLE_BITS)) u_blend_y (
    .clk(clk), .rst(rst), .start(blend_start), .comp(filt_y), .acc(uy_angle),
    .omega((SB+1)'(rate_x_q)), .weight(blend_weight), .gain(rate_gain),
    .valid(by_valid), .angle(by_angle)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      blend_weight <= tcf_pkg::BLEND_WEIGHT_RESET;
      rate_gain    <= tcf_pkg::RATE_GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tcf_pkg::CFG_BLEND_WEIGHT: blend_weight <= cfg_data[15:0];
        tcf_pkg::CFG_RATE_GAIN:    rate_gain    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcf_pkg::T_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state of the top sequencer.
  always_comb begin
    state_next = state;
    case (state)
      tcf_pkg::T_IDLE: if (in_fire) state_next = tcf_pkg::T_ANGLE;
      tcf_pkg::T_ANGLE: begin
        if (ux_done) begin
          state_next = (mode_q == tcf_pkg::MODE_UPDATE) ? tcf_pkg::T_BLEND : tcf_pkg::T_STORE;
        end
      end
      tcf_pkg::T_BLEND: if (bx_valid) state_next = tcf_pkg::T_STORE;
      tcf_pkg::T_STORE: if (out_free) state_next = tcf_pkg::T_IDLE;
      default:          state_next = tcf_pkg::T_IDLE;
    endcase
  end

  // Captured item fields and accelerometer angles.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_q   <= s_tuser;
      rate_x_q <= rx;
      rate_y_q <= ry;
    end
    if ((state == tcf_pkg::T_ANGLE) && ux_done) begin
      acc_x <= ux_angle;
      acc_y <= uy_angle;
    end
  end

  // Filter state: seeded on start, blended on update.
  always_ff @(posedge clk) begin
    if (rst) begin
      filt_x <= '0;
      filt_y <= '0;
    end else if ((state == tcf_pkg::T_ANGLE) && ux_done && (mode_q == tcf_pkg::MODE_START)) begin
      filt_x <= ux_angle;
      filt_y <= uy_angle;
    end else if ((state == tcf_pkg::T_BLEND) && bx_valid) begin
      filt_x <= bx_angle;
      filt_y <= by_angle;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == tcf_pkg::T_STORE) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == tcf_pkg::T_STORE) && out_free) begin
      m_tdata <= OUT_W'({acc_y, acc_x, filt_y, filt_x});
    end
  end

  // Both angle units run in lockstep.
  a_units_lockstep: assert property (@(posedge clk) disable iff (rst) ux_done == uy_done)
    else $error("angle units out of step");

  // Blend results appear only while the sequencer waits for them.
  a_blend_expected: assert property (@(posedge clk) disable iff (rst)
    (bx_valid || by_valid) |-> (state == tcf_pkg::T_BLEND && bx_valid && by_valid))
    else $error("unexpected blend result");

  // A transaction on the input closes the input until its result is stored.
  a_one_item: assert property (@(posedge clk) disable iff (rst) in_fire |=> !s_tready)
    else $error("second item accepted while busy");

endmodule

### sim/tb.sv
// Self-checking testbench of the complementary tilt filter with a scoreboard class.
`timescale 1ns / 1ps

module tb;

  localparam int ANGLE_BITS = 20;
  localparam int SAMPLE_BITS = 16;
  localparam int CORDIC_STEPS = 20;
  localparam int IN_W = ((5*SAMPLE_BITS+7)/8)*8;
  localparam int OUT_W = ((4*ANGLE_BITS+7)/8)*8;
  localparam int RANDOM_ITEMS = 850;
  localparam longint CYCLE_LIMIT = 2000000;
  localparam longint ANGLE_FULL = 64'd1 << ANGLE_BITS;
  localparam longint ANGLE_HALF = ANGLE_FULL / 2;

  typedef struct {
    logic mode;
    logic signed [15:0] ax, ay, az, gx, gy;
  } sample_t;

  typedef struct packed {
    logic [19:0] tilt_x, tilt_y, acc_x, acc_y;
  } tilt_t;

  // Tilt predictor and queue of predicted results.
  class tilt_scoreboard;
    logic [15:0] alpha;
    logic [23:0] gain;
    logic [19:0] angle_x, angle_y;
    tilt_t pending[$];
    int mismatches;
    int checked;

    function void reset_state();
      alpha = tcf_pkg::BLEND_WEIGHT_RESET;
      gain = tcf_pkg::RATE_GAIN_RESET;
      angle_x = '0;
      angle_y = '0;
      pending.delete();
    endfunction

    function void write_reg(logic [7:0] idx, logic [23:0] val);
      if (idx == tcf_pkg::CFG_BLEND_WEIGHT) alpha = val[15:0];
      else if (idx == tcf_pkg::CFG_RATE_GAIN) gain = val;
    endfunction

    // Arithmetic shifts on longint floor toward minus infinity.
    function logic [19:0] accel_angle(longint a, longint b, longint c, bit zneg);
      longint unsigned sum, n, r, bitv;
      longint x, y, xs, ys;
      logic [31:0] z;
      sum = longint'(b*b) + longint'(c*c);
      n = sum << (2*(30-SAMPLE_BITS));
      r = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
        if (n >= r + bitv) begin
          n -= r + bitv;
          r = (r >> 1) + bitv;
        end else begin
          r >>= 1;
        end
        bitv >>= 2;
      end
      x = longint'(r);
      y = a <<< (30-SAMPLE_BITS);
      z = '0;
      if (x != 0 || y != 0) begin
        for (int i = 0; i < CORDIC_STEPS; i++) begin
          xs = x >>> i;
          ys = y >>> i;
          if (y >= 0) begin
            x += ys; y -= xs; z += arctan_table(i);
          end else begin
            x -= ys; y += xs; z -= arctan_table(i);
          end
        end
      end
      if (zneg) z = 32'h80000000 - z;
      return 20'((longint'(z) + (64'd1 << (31-ANGLE_BITS))) >> (32-ANGLE_BITS));
    endfunction

    function logic [31:0] arctan_table(int i);
      logic [31:0] t [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000};
      return t[i];
    endfunction

    function logic [19:0] blend_angle(logic [19:0] comp, logic [19:0] acc, longint omega);
      longint diff, inc, p;
      diff = longint'(comp) - longint'(acc);
      if (diff > ANGLE_HALF) diff -= ANGLE_FULL;
      else if (diff < -ANGLE_HALF) diff += ANGLE_FULL;
      inc = (omega * longint'(gain)) >>> 16;
      p = ((diff + inc) * longint'(alpha) + 32768) >>> 16;
      return 20'(longint'(acc) + p);
    endfunction

    function void note_sample(sample_t s);
      tilt_t e;
      e.acc_x = accel_angle(s.ax, s.ay, s.az, s.az < 0);
      e.acc_y = accel_angle(s.ay, s.ax, s.az, s.az < 0);
      if (s.mode == tcf_pkg::MODE_UPDATE) begin
        angle_x = blend_angle(angle_x, e.acc_x, -longint'(s.gy));
        angle_y = blend_angle(angle_y, e.acc_y, longint'(s.gx));
      end else begin
        angle_x = e.acc_x;
        angle_y = e.acc_y;
      end
      e.tilt_x = angle_x;
      e.tilt_y = angle_y;
      pending.push_back(e);
    endfunction

    function void check_result(logic [OUT_W-1:0] d);
      tilt_t e, g;
      g.tilt_x = d[19:0]; g.tilt_y = d[39:20];
      g.acc_x = d[59:40]; g.acc_y = d[79:60];
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", d);
        return;
      end
      e = pending.pop_front();
      if (e != g) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp %h %h %h %h got %h %h %h %h", e.tilt_x, e.tilt_y,
                   e.acc_x, e.acc_y, g.tilt_x, g.tilt_y, g.acc_x, g.acc_y);
      end
    endfunction
  endclass

  logic clk, rst;
  logic s_tvalid, s_tready, s_tuser;
  logic [IN_W-1:0] s_tdata;
  logic m_tvalid, m_tready;
  logic [OUT_W-1:0] m_tdata;
  logic cfg_valid, cfg_ready;
  logic [7:0] cfg_index;
  logic [23:0] cfg_data;

  tilt_scoreboard sb;
  longint cycles;
  int sent;
  bit stim_done;

  tilt_complementary_filter #(
    .ANGLE_BITS(ANGLE_BITS), .SAMPLE_BITS(SAMPLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)
  ) u_dut (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Cycle count and timeout.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  // Result side: random stall per transaction, checked at the rising edge.
  initial begin
    int w;
    m_tready = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      m_tready = 0;
      repeat (w) @(negedge clk);
      m_tready = 1;
      do @(posedge clk); while (!m_tvalid);
      sb.check_result(m_tdata);
      @(negedge clk);
    end
  end

  task automatic send_sample(sample_t s, bit no_gap = 0);
    int w;
    w = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
    repeat (w) @(negedge clk);
    s_tdata = IN_W'({s.gy, s.gx, s.az, s.ay, s.ax});
    s_tuser = s.mode;
    s_tvalid = 1;
    do @(posedge clk); while (!s_tready);
    sb.note_sample(s);
    sent++;
    @(negedge clk);
    s_tvalid = 0;
  endtask

  task automatic write_reg(logic [7:0] idx, logic [23:0] val);
    cfg_index = idx;
    cfg_data = val;
    cfg_valid = 1;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  // Wait for every result, then for the block's own latency.
  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sd0;
      3: return 16'($signed($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic sample_t rand_sample(logic mode);
    sample_t s;
    s.mode = mode;
    s.ax = pick_sample(); s.ay = pick_sample(); s.az = pick_sample();
    s.gx = pick_sample(); s.gy = pick_sample();
    return s;
  endfunction

  initial begin
    sample_t s;
    logic [15:0] alphas [4] = '{16'd0, 16'hFFFF, 16'd64225, 16'd32768};
    logic [23:0] gains [4] = '{24'hFFFFFF, 24'd0, 24'd65536, 24'd300};
    sb = new();
    sb.reset_state();
    cycles = 0; sent = 0; stim_done = 0;
    s_tvalid = 0; s_tuser = 0; s_tdata = '0;
    cfg_valid = 0; cfg_index = '0; cfg_data = '0;
    rst = 1;
    repeat (4) @(negedge clk);
    rst = 0;

    // Directed: update before start, zero vector, z zero, z negative, extremes.
    send_sample('{tcf_pkg::MODE_UPDATE, 16'sd100, -16'sd50, 16'sd0, 16'sd7, -16'sd9});
    send_sample('{tcf_pkg::MODE_START, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
    send_sample('{tcf_pkg::MODE_UPDATE, 16'sd0, 16'sd0, 16'sd0, 16'sh7FFF, 16'sh8000});
    send_sample('{tcf_pkg::MODE_START, -16'sd1000, -16'sd1000, 16'sd0, 16'sd0, 16'sd0});
    send_sample('{tcf_pkg::MODE_UPDATE, 16'sd1000, 16'sd500, -16'sd300, 16'sd10, 16'sd10});
    send_sample('{tcf_pkg::MODE_START, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                  16'sh7FFF});
    send_sample('{tcf_pkg::MODE_UPDATE, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                  16'sh8000});
    send_sample('{tcf_pkg::MODE_UPDATE, 16'sh7FFF, 16'sh8000, -16'sd1, -16'sd1, 16'sd1});
    // Near half-turn differences: flip between upright and mirrored.
    send_sample('{tcf_pkg::MODE_START, 16'sd0, 16'sd0, 16'sd1000, 16'sd0, 16'sd0});
    send_sample('{tcf_pkg::MODE_UPDATE, 16'sd0, 16'sd0, -16'sd1000, 16'sd0, 16'sd0});
    send_sample('{tcf_pkg::MODE_UPDATE, 16'sd0, 16'sd0, 16'sd1000, 16'sd0, 16'sd0});
    send_sample('{tcf_pkg::MODE_UPDATE, -16'sd1, 16'sd1, 16'sh8000, 16'sd3, -16'sd3});

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      if (ph < 4) begin
        write_reg(tcf_pkg::CFG_BLEND_WEIGHT, {8'h00, alphas[ph]});
        write_reg(tcf_pkg::CFG_RATE_GAIN, gains[ph]);
      end else begin
        write_reg(tcf_pkg::CFG_BLEND_WEIGHT, 24'($urandom));
        write_reg(tcf_pkg::CFG_RATE_GAIN, 24'($urandom));
      end
      for (int i = 0; i < RANDOM_ITEMS / 5; i++) begin
        // Mostly updates after an occasional start; runs without gaps now and then.
        s = rand_sample($urandom_range(0, 7) != 0);
        send_sample(s, (i / 20) % 3 == 1);
      end
    end
    drain();
    stim_done = 1;

    $display("%0d samples sent, %0d results checked over five register settings",
             sent, sb.checked);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
      $display("status: fail");
    end
    $finish;
  end
endmodule
